// File: hdl/lcq_pkg.sv
// ----------------------------------------------------------------------------
// lcq_pkg: shared types, sizes and activations for the quantized LSTM cell
// Holds the table sizes, item kinds, controller states, inter-module
// structs and the piecewise-linear activation functions.
// ----------------------------------------------------------------------------
package lcq_pkg;

	localparam int INPUT_SIZE  = 16;
	localparam int HIDDEN_SIZE = 16;
	localparam int NGATE       = 4 * HIDDEN_SIZE;
	localparam int NCOL        = INPUT_SIZE + HIDDEN_SIZE;
	localparam int IW_DEPTH    = NGATE * INPUT_SIZE;
	localparam int RW_DEPTH    = NGATE * HIDDEN_SIZE;

	localparam int IW_AW = $clog2(IW_DEPTH);
	localparam int RW_AW = $clog2(RW_DEPTH);
	localparam int ROW_W = $clog2(NGATE);
	localparam int COL_W = $clog2(NCOL);
	localparam int IN_W  = (INPUT_SIZE > 1) ? $clog2(INPUT_SIZE) : 1;
	localparam int HID_W = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;

	// one 16-bit product per column plus the scaled bias
	localparam int SUM_W = 16 + $clog2(NCOL + 1);

	localparam int QOUT       = 4;
	localparam int SIG_LIMIT  = 4 << 11;
	localparam int SIG_HALF   = 1 << (11 - 1);
	localparam int SIG_ROUND  = 1 << 6;
	localparam int TANH_LIMIT = 1 << 11;
	localparam int ACT_SHIFT  = 11 - QOUT;
	localparam int ACT_MAX    = 1 << QOUT;

	typedef enum logic [2:0] {
		KIND_IW   = 3'd0,
		KIND_RW   = 3'd1,
		KIND_BIAS = 3'd2,
		KIND_IN   = 3'd3,
		KIND_HID  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic              we;
		logic [2:0]        kind;
		logic [9:0]        index;
		logic signed [7:0] value;
	} load_t;

	typedef struct packed {
		logic              issue;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic signed [7:0] elem;
	} walk_t;

	typedef struct packed {
		logic                    push;
		logic                    fin;
		logic signed [SUM_W-1:0] sum;
	} push_t;

	typedef struct packed {
		logic                    valid;
		logic [3:0]              unit;
		logic                    last;
		logic signed [SUM_W-1:0] gi;
		logic signed [SUM_W-1:0] gf;
		logic signed [SUM_W-1:0] gg;
		logic signed [SUM_W-1:0] go;
		logic signed [15:0]      cell_prev;
	} act_in_t;

	function automatic logic signed [5:0] act_sig(logic signed [SUM_W-1:0] a);
		logic signed [SUM_W-1:0] t;
		t = (a >>> 3) + SUM_W'(SIG_HALF + SIG_ROUND);
		t = t >>> ACT_SHIFT;
		if (a > SUM_W'(SIG_LIMIT))
			return 6'(ACT_MAX);
		else if (a < -SUM_W'(SIG_LIMIT))
			return 6'sd0;
		else
			return 6'(t);
	endfunction

	function automatic logic signed [5:0] act_tanh(logic signed [SUM_W-1:0] a);
		logic signed [SUM_W-1:0] t;
		t = a >>> ACT_SHIFT;
		if (a > SUM_W'(TANH_LIMIT))
			return 6'(ACT_MAX);
		else if (a < -SUM_W'(TANH_LIMIT))
			return -6'(ACT_MAX);
		else
			return 6'(t);
	endfunction

	// tanh of a cell value scaled by eight
	function automatic logic signed [5:0] act_tanh_cell(logic signed [15:0] c);
		logic signed [18:0] x;
		logic signed [18:0] t;
		x = {c, 3'b000};
		t = x >>> ACT_SHIFT;
		if (x > 19'(TANH_LIMIT))
			return 6'(ACT_MAX);
		else if (x < -19'(TANH_LIMIT))
			return -6'(ACT_MAX);
		else
			return 6'(t);
	endfunction

endpackage

// File: hdl/lstm_cell_quantized_top.sv
// ----------------------------------------------------------------------------
// lstm_cell_quantized_top: int8 LSTM cell with piecewise-linear activations
// Loads weights, biases and vectors; a hidden request marked last runs one
// step and emits the new cell and hidden value of every unit in order.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                 Payload
// request   start, busy (in: start)   kind, index, value, cell_value, last
// result    result_strobe (out)       unit, new_hidden, new_cell, last_unit
//
// Requests are taken whenever busy is low.
// A step walks all 4*HIDDEN_SIZE gate rows over INPUT_SIZE+HIDDEN_SIZE
// columns, one weight of each memory per cycle, waits for the accumulate
// pipeline to drain, then emits HIDDEN_SIZE units on consecutive cycles;
// each result passes the s1, s2 and output registers of lcq_act.
// busy stays high from the triggering request until the last result.
// Reset clears only control state; tables hold garbage until written.
// Results cannot be stalled: each strobe lasts exactly one cycle.
// ----------------------------------------------------------------------------
module lstm_cell_quantized_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic [9:0]         index,
	input  logic signed [7:0]  value,
	input  logic signed [15:0] cell_value,
	input  logic               last,
	output logic               result_strobe,
	output logic [3:0]         unit,
	output logic signed [5:0]  new_hidden,
	output logic signed [15:0] new_cell,
	output logic               last_unit
);

	lcq_pkg::state_t state_q, state_next;

	logic accept, trigger, issue, emit, chain_shift;

	logic signed [7:0]  in_vec   [lcq_pkg::INPUT_SIZE];
	logic signed [7:0]  hid_vec  [lcq_pkg::HIDDEN_SIZE];
	logic signed [15:0] cell_vec [lcq_pkg::HIDDEN_SIZE];

	logic [lcq_pkg::ROW_W-1:0] row_q;
	logic [lcq_pkg::COL_W-1:0] col_q;
	logic                      issued_q;
	logic [lcq_pkg::HID_W-1:0] u_q;
	logic                      u_last;

	lcq_pkg::load_t   load;
	lcq_pkg::walk_t   walk;
	lcq_pkg::push_t   push;
	lcq_pkg::act_in_t ain;

	logic signed [lcq_pkg::SUM_W-1:0] chain [lcq_pkg::NGATE];

	assign accept  = start && !busy;
	assign trigger = accept && kind == lcq_pkg::KIND_HID && last;
	assign u_last  = u_q == lcq_pkg::HID_W'(lcq_pkg::HIDDEN_SIZE - 1);

	// vector stores: written only by accepted requests
	always_ff @(posedge clk) begin
		if (accept && kind == lcq_pkg::KIND_IN
			&& {1'b0, index} < 11'(lcq_pkg::INPUT_SIZE))
			in_vec[lcq_pkg::IN_W'(index)] <= value;
		if (accept && kind == lcq_pkg::KIND_HID
			&& {1'b0, index} < 11'(lcq_pkg::HIDDEN_SIZE)) begin
			hid_vec[lcq_pkg::HID_W'(index)]  <= value;
			cell_vec[lcq_pkg::HID_W'(index)] <= cell_value;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			lcq_pkg::ST_IDLE:  if (trigger) state_next = lcq_pkg::ST_WALK;
			lcq_pkg::ST_WALK:  if (push.fin) state_next = lcq_pkg::ST_EMIT;
			lcq_pkg::ST_EMIT:  if (u_last) state_next = lcq_pkg::ST_FLUSH;
			lcq_pkg::ST_FLUSH: if (result_strobe && last_unit) state_next = lcq_pkg::ST_IDLE;
			default:           state_next = lcq_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy  = state_q != lcq_pkg::ST_IDLE;
		issue = state_q == lcq_pkg::ST_WALK && !issued_q;
		emit  = state_q == lcq_pkg::ST_EMIT;
	end

	assign chain_shift = push.push || emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lcq_pkg::ST_IDLE;
		else
			state_q <= state_next;
	end

	// walk and emit counters: rewind while idle, advance one column a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			issued_q <= 1'b0;
			u_q      <= '0;
		end else if (state_q == lcq_pkg::ST_IDLE) begin
			row_q    <= '0;
			col_q    <= '0;
			issued_q <= 1'b0;
			u_q      <= '0;
		end else begin
			if (issue) begin
				if (col_q == lcq_pkg::COL_W'(lcq_pkg::NCOL - 1)) begin
					col_q <= '0;
					if (row_q == lcq_pkg::ROW_W'(lcq_pkg::NGATE - 1))
						issued_q <= 1'b1;
					else
						row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (emit)
				u_q <= u_q + 1'b1;
		end
	end

	assign load.we    = accept;
	assign load.kind  = kind;
	assign load.index = index;
	assign load.value = value;

	assign walk.issue = issue;
	assign walk.row   = row_q;
	assign walk.col   = col_q;
	assign walk.elem  = (col_q < lcq_pkg::COL_W'(lcq_pkg::INPUT_SIZE))
		? in_vec[lcq_pkg::IN_W'(col_q)]
		: hid_vec[lcq_pkg::HID_W'(col_q - lcq_pkg::COL_W'(lcq_pkg::INPUT_SIZE))];

	lcq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.walk   (walk),
		.push   (push)
	);

	// gate sum chain: finished rows enter at the top, drain toward link 0;
	// while emitting, link k*HIDDEN_SIZE holds gate k of the current unit
	for (genvar k = 0; k < lcq_pkg::NGATE; k++) begin : g_chain
		if (k == lcq_pkg::NGATE - 1) begin : g_top
			lcq_sum_cell u_cell (
				.clk   (clk),
				.shift (chain_shift),
				.d     (push.sum),
				.q     (chain[k])
			);
		end else begin : g_mid
			lcq_sum_cell u_cell (
				.clk   (clk),
				.shift (chain_shift),
				.d     (chain[k+1]),
				.q     (chain[k])
			);
		end
	end

	assign ain.valid     = emit;
	assign ain.unit      = 4'(u_q);
	assign ain.last      = u_last;
	assign ain.gi        = chain[0];
	assign ain.gf        = chain[lcq_pkg::HIDDEN_SIZE];
	assign ain.gg        = chain[2 * lcq_pkg::HIDDEN_SIZE];
	assign ain.go        = chain[3 * lcq_pkg::HIDDEN_SIZE];
	assign ain.cell_prev = cell_vec[u_q];

	lcq_act u_act (
		.clk           (clk),
		.arst_n        (arst_n),
		.ain           (ain),
		.result_strobe (result_strobe),
		.unit          (unit),
		.new_hidden    (new_hidden),
		.new_cell      (new_cell),
		.last_unit     (last_unit)
	);

endmodule

// File: hdl/lcq_sum_cell.sv
// ----------------------------------------------------------------------------
// lcq_sum_cell: one link of the gate sum chain
// Holds one gate sum and takes its neighbor's value on every shift.
// ----------------------------------------------------------------------------
module lcq_sum_cell (
	input  logic                           clk,
	input  logic                           shift,
	input  logic signed [lcq_pkg::SUM_W-1:0] d,
	output logic signed [lcq_pkg::SUM_W-1:0] q
);

	logic signed [lcq_pkg::SUM_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (shift)
			sum_q <= d;
	end

	assign q = sum_q;

endmodule

// File: hdl/lcq_mac.sv
// ----------------------------------------------------------------------------
// lcq_mac: weight and bias memories with the multiply-accumulate pipeline
// Reads one input and one recurrent weight per cycle, multiplies by the
// current element and accumulates one gate row; pushes each finished row.
// ----------------------------------------------------------------------------
module lcq_mac (
	input  logic            clk,
	input  logic            arst_n,
	input  lcq_pkg::load_t  load,
	input  lcq_pkg::walk_t  walk,
	output lcq_pkg::push_t  push
);

	logic signed [7:0] iw_mem   [lcq_pkg::IW_DEPTH];
	logic signed [7:0] rw_mem   [lcq_pkg::RW_DEPTH];
	logic signed [7:0] bias_mem [lcq_pkg::NGATE];

	logic                     iw_we, rw_we, bias_we;
	logic [lcq_pkg::IW_AW-1:0] iw_ra;
	logic [lcq_pkg::RW_AW-1:0] rw_ra;

	logic signed [7:0]  iw_s1, rw_s1, bias_s1, e_s1;
	logic               hid_s1, v_s1, first_s1, lastc_s1, fin_s1;
	logic signed [15:0] prod;
	logic signed [15:0] prod_s2;
	logic signed [lcq_pkg::SUM_W-1:0] bias_s2;
	logic               v_s2, first_s2, lastc_s2, fin_s2;
	logic signed [lcq_pkg::SUM_W-1:0] acc_q, acc_next;

	assign iw_we = load.we && load.kind == lcq_pkg::KIND_IW
		&& {1'b0, load.index} < 11'(lcq_pkg::IW_DEPTH);
	assign rw_we = load.we && load.kind == lcq_pkg::KIND_RW
		&& {1'b0, load.index} < 11'(lcq_pkg::RW_DEPTH);
	assign bias_we = load.we && load.kind == lcq_pkg::KIND_BIAS
		&& {1'b0, load.index} < 11'(lcq_pkg::NGATE);

	assign iw_ra = lcq_pkg::IW_AW'(walk.row) * lcq_pkg::IW_AW'(lcq_pkg::INPUT_SIZE)
		+ lcq_pkg::IW_AW'(walk.col);
	assign rw_ra = lcq_pkg::RW_AW'(walk.row) * lcq_pkg::RW_AW'(lcq_pkg::HIDDEN_SIZE)
		+ lcq_pkg::RW_AW'(walk.col - lcq_pkg::COL_W'(lcq_pkg::INPUT_SIZE));

	always_ff @(posedge clk) begin
		if (iw_we)
			iw_mem[lcq_pkg::IW_AW'(load.index)] <= load.value;
		if (rw_we)
			rw_mem[lcq_pkg::RW_AW'(load.index)] <= load.value;
		if (bias_we)
			bias_mem[lcq_pkg::ROW_W'(load.index)] <= load.value;
		iw_s1   <= iw_mem[iw_ra];
		rw_s1   <= rw_mem[rw_ra];
		bias_s1 <= bias_mem[walk.row];
		e_s1    <= walk.elem;
		hid_s1  <= walk.col >= lcq_pkg::COL_W'(lcq_pkg::INPUT_SIZE);
	end

	assign prod = (hid_s1 ? rw_s1 : iw_s1) * e_s1;

	always_ff @(posedge clk) begin
		prod_s2 <= prod;
		bias_s2 <= lcq_pkg::SUM_W'(bias_s1) <<< 4;
	end

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			lastc_s1 <= 1'b0;
			fin_s1   <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
			lastc_s2 <= 1'b0;
			fin_s2   <= 1'b0;
		end else begin
			v_s1     <= walk.issue;
			first_s1 <= walk.col == '0;
			lastc_s1 <= walk.col == lcq_pkg::COL_W'(lcq_pkg::NCOL - 1);
			fin_s1   <= walk.col == lcq_pkg::COL_W'(lcq_pkg::NCOL - 1)
				&& walk.row == lcq_pkg::ROW_W'(lcq_pkg::NGATE - 1);
			v_s2     <= v_s1;
			first_s2 <= first_s1;
			lastc_s2 <= lastc_s1;
			fin_s2   <= fin_s1;
		end
	end

	assign acc_next = (first_s2 ? bias_s2 : acc_q) + lcq_pkg::SUM_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (v_s2)
			acc_q <= acc_next;
	end

	assign push.push = v_s2 && lastc_s2;
	assign push.fin  = v_s2 && lastc_s2 && fin_s2;
	assign push.sum  = acc_next;

endmodule

// File: hdl/lcq_act.sv
// ----------------------------------------------------------------------------
// lcq_act: activation and cell update pipeline
// Turns the four gate sums of one unit into the new cell and hidden value.
// ----------------------------------------------------------------------------
module lcq_act (
	input  logic               clk,
	input  logic               arst_n,
	input  lcq_pkg::act_in_t   ain,
	output logic               result_strobe,
	output logic [3:0]         unit,
	output logic signed [5:0]  new_hidden,
	output logic signed [15:0] new_cell,
	output logic               last_unit
);

	logic               v_s1, last_s1, v_s2, last_s2;
	logic [3:0]         unit_s1, unit_s2;
	logic signed [5:0]  ig_s1, fg_s1, gg_s1, og_s1, og_s2;
	logic signed [11:0] cs_s1;
	logic signed [17:0] nc_full;
	logic signed [15:0] nc_s2;
	logic signed [5:0]  tc;
	logic signed [11:0] nh_full;

	logic               strobe_q, last_q;
	logic [3:0]         unit_q;
	logic signed [5:0]  nh_q;
	logic signed [15:0] nc_q;

	always_ff @(posedge clk) begin
		ig_s1   <= lcq_pkg::act_sig(ain.gi);
		fg_s1   <= lcq_pkg::act_sig(ain.gf);
		gg_s1   <= lcq_pkg::act_tanh(ain.gg);
		og_s1   <= lcq_pkg::act_sig(ain.go);
		cs_s1   <= 12'(ain.cell_prev >>> 4);
		unit_s1 <= ain.unit;
		nc_s2   <= nc_full[15:0];
		og_s2   <= og_s1;
		unit_s2 <= unit_s1;
		nh_q    <= 6'(nh_full >>> 4);
		nc_q    <= nc_s2;
		unit_q  <= unit_s2;
	end

	// wrap the cell update to 16 bits
	assign nc_full = fg_s1 * cs_s1 + ig_s1 * gg_s1;
	assign tc      = lcq_pkg::act_tanh_cell(nc_s2);
	assign nh_full = og_s2 * tc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			last_s2  <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			v_s1     <= ain.valid;
			last_s1  <= ain.valid && ain.last;
			v_s2     <= v_s1;
			last_s2  <= last_s1;
			strobe_q <= v_s2;
			last_q   <= last_s2;
		end
	end

	assign result_strobe = strobe_q;
	assign unit          = unit_q;
	assign new_hidden    = nh_q;
	assign new_cell      = nc_q;
	assign last_unit     = last_q;

endmodule

// File: hdl/lcq_checker.sv
// ----------------------------------------------------------------------------
// lcq_checker: port-level checks for the quantized LSTM cell
// Watches the request and result ports over time.
// ----------------------------------------------------------------------------
module lcq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [2:0]         kind,
	input logic               last,
	input logic               result_strobe,
	input logic [3:0]         unit,
	input logic               last_unit
);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> busy)
		else $error("result outside a step");

	a_trigger_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == 3'(lcq_pkg::KIND_HID) && last) |=> busy)
		else $error("step request did not raise busy");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_unit) |=> result_strobe)
		else $error("gap inside result burst");

	a_unit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_unit) |=> unit == 4'($past(unit) + 4'd1))
		else $error("units out of order");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_unit) |=> !result_strobe)
		else $error("result after the last unit");

endmodule

bind lstm_cell_quantized_top lcq_checker u_lcq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.kind          (kind),
	.last          (last),
	.result_strobe (result_strobe),
	.unit          (unit),
	.last_unit     (last_unit)
);
